FILE: hw/rtl/slcp_pkg.sv
// Shared types and constants for the spectrum level color picker.
// Used by slcp_ctrl, slcp_dp and spectrum_level_color_picker; no dependencies.
package slcp_pkg;

    localparam int BINS        = 64;
    localparam int TABLE_DEPTH = 512;

    localparam int SAMPLE_W = 16;
    localparam int COLOR_W  = 24;
    localparam int LEVEL_W  = 9;
    localparam int INDEX_W  = 9;
    localparam int SUM_W    = 22;
    localparam int COUNT_W  = 7;
    localparam int DIVS_W   = 8;
    localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int POS_W    = $clog2(BINS + 1);

    localparam int DIV_BIAS  = 10;
    localparam int LEVEL_MAX = 511;
    localparam int LEVEL_LIM = (TABLE_DEPTH - 1 < LEVEL_MAX) ? TABLE_DEPTH - 1 : LEVEL_MAX;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic KIND_TABLE = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] left_bin;
        logic signed [SAMPLE_W-1:0] right_bin;
        logic                       frame_last;
        logic [INDEX_W-1:0]         table_index;
        logic [COLOR_W-1:0]         table_color;
    } t_in;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [LEVEL_W-1:0] level;
    } t_out;

    typedef struct packed {
        logic tbl_wr;
        logic bin_acc;
        logic frame_end;
        logic div_step;
        logic mem_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage

FILE: hw/rtl/slcp_dp.sv
// Datapath of the spectrum level color picker: accumulator, restoring divider,
// color table memory and output register. Depends on slcp_pkg.
module slcp_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  slcp_pkg::t_in  i_in_data,
    input  slcp_pkg::t_cmd i_cmd,
    output slcp_pkg::t_stat o_stat,
    output slcp_pkg::t_out o_out_data
);

    logic [slcp_pkg::SUM_W-1:0]   r_sum;
    logic [slcp_pkg::COUNT_W-1:0] r_cnt;
    logic [slcp_pkg::POS_W-1:0]   r_pos;
    logic [slcp_pkg::STEP_W-1:0]  r_step;
    logic [slcp_pkg::SUM_W-1:0]   r_quo;
    logic [slcp_pkg::DIVS_W-1:0]  r_rem;
    logic [slcp_pkg::DIVS_W-1:0]  r_dvs;
    logic [slcp_pkg::COLOR_W-1:0] r_rdata;
    logic [slcp_pkg::LEVEL_W-1:0] r_lvl;
    slcp_pkg::t_out               r_out;
    logic [slcp_pkg::COLOR_W-1:0] r_color_store [slcp_pkg::TABLE_DEPTH];

    logic signed [slcp_pkg::SAMPLE_W:0] pair;
    logic                               pair_pos;
    logic                               in_window;
    logic [slcp_pkg::SUM_W:0]           sum_add;
    logic [slcp_pkg::SUM_W-1:0]         n_sum;
    logic [slcp_pkg::COUNT_W-1:0]       n_cnt;
    logic [slcp_pkg::DIVS_W:0]          rem_shift;
    logic                               quo_bit;
    logic [slcp_pkg::LEVEL_W-1:0]       lvl;

    always_comb begin
        pair      = (slcp_pkg::SAMPLE_W+1)'(i_in_data.left_bin)
                  + (slcp_pkg::SAMPLE_W+1)'(i_in_data.right_bin);
        pair_pos  = !pair[slcp_pkg::SAMPLE_W] && (pair[slcp_pkg::SAMPLE_W-1:1] != '0);
        in_window = r_pos < slcp_pkg::POS_W'(slcp_pkg::BINS);
        sum_add   = (slcp_pkg::SUM_W+1)'(r_sum)
                  + (slcp_pkg::SUM_W+1)'(pair[slcp_pkg::SAMPLE_W-1:1]);
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        if (in_window && pair_pos) begin
            n_sum = sum_add[slcp_pkg::SUM_W] ? '1 : sum_add[slcp_pkg::SUM_W-1:0];
            if (r_cnt != '1) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        rem_shift = {r_rem, r_quo[slcp_pkg::SUM_W-1]};
        quo_bit   = rem_shift >= (slcp_pkg::DIVS_W+1)'(r_dvs);
        if (r_quo > slcp_pkg::SUM_W'(slcp_pkg::LEVEL_LIM)) begin
            lvl = slcp_pkg::LEVEL_W'(slcp_pkg::LEVEL_LIM);
        end else begin
            lvl = r_quo[slcp_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_pos  <= '0;
            r_step <= '0;
        end else begin
            if (i_cmd.bin_acc) begin
                if (i_cmd.frame_end) begin
                    r_sum  <= '0;
                    r_cnt  <= '0;
                    r_pos  <= '0;
                    r_step <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    if (in_window) begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
            end
            if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_end) begin
            r_quo <= n_sum;
            r_dvs <= slcp_pkg::DIVS_W'(n_cnt) + slcp_pkg::DIVS_W'(slcp_pkg::DIV_BIAS);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[slcp_pkg::SUM_W-2:0], quo_bit};
            if (quo_bit) begin
                r_rem <= slcp_pkg::DIVS_W'(rem_shift - (slcp_pkg::DIVS_W+1)'(r_dvs));
            end else begin
                r_rem <= rem_shift[slcp_pkg::DIVS_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out.color <= r_rdata;
            r_out.level <= r_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr
                && (32'(i_in_data.table_index) < 32'(slcp_pkg::TABLE_DEPTH))) begin
            r_color_store[slcp_pkg::ADDR_W'(i_in_data.table_index)] <= i_in_data.table_color;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_color_store[slcp_pkg::ADDR_W'(lvl)];
            r_lvl   <= lvl;
        end
    end

    assign o_stat.div_done = (r_step == slcp_pkg::STEP_W'(slcp_pkg::DIV_STEPS - 1));
    assign o_out_data      = r_out;

    a_cnt_zero_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_sum == '0))
        else $error("sum is nonzero while the positive count is zero");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= slcp_pkg::POS_W'(slcp_pkg::BINS))
        else $error("bin position ran past the frame window");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.bin_acc && i_cmd.frame_end) |=>
            (r_sum == '0 && r_cnt == '0 && r_pos == '0 && r_step == '0))
        else $error("frame end did not clear the accumulator");

endmodule

FILE: hw/rtl/slcp_ctrl.sv
// Controller of the spectrum level color picker: sequences accumulation,
// division, table read and result hand-off. Depends on slcp_pkg.
module slcp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_kind,
    input  logic            i_last,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  slcp_pkg::t_stat i_stat,
    output slcp_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_cmd.tbl_wr  = accept && (i_kind == slcp_pkg::KIND_TABLE);
                o_cmd.bin_acc = accept && (i_kind == slcp_pkg::KIND_BIN);
                if (o_cmd.bin_acc && i_last) begin
                    o_cmd.frame_end = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("result load did not raise output valid");

    a_end_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.frame_end |=> (r_state == S_DIV))
        else $error("frame end did not start the divider");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_LOAD))
        else $error("output valid rose outside the load state");

endmodule

FILE: hw/rtl/spectrum_level_color_picker.sv
// Top level of the spectrum level color picker: joins controller and datapath.
// Depends on slcp_pkg, slcp_ctrl and slcp_dp.
//
//   channel   direction   handshake                  payload
//   input     in          i_in_valid / o_in_ready    i_in_data  (slcp_pkg::t_in)
//   result    out         o_out_valid / i_out_ready  o_out_data (slcp_pkg::t_out)
//
// Table writes and bins that do not close a frame are taken one per cycle.
// A bin marked last runs a restoring divider, one quotient bit per cycle, in S_DIV,
// then a table read in S_READ and the result load in S_LOAD; its result becomes valid
// in the same cycle as input ready returns.
// A result still waiting for transfer holds the next result in its load cycle,
// and input stalls until the waiting result is taken.
// Reset is synchronous, active low, and clears the accumulator and all control.
module spectrum_level_color_picker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  slcp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output slcp_pkg::t_out o_out_data
);

    slcp_pkg::t_cmd  cmd;
    slcp_pkg::t_stat stat;

    slcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in_data.kind),
        .i_last      (i_in_data.frame_last),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    slcp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule
